// ===== design/srtf_pkg.sv =====
// shared types, constants and codes of the srtf scheduler
`default_nettype none

package srtf_pkg;

    localparam int SLOTS  = 64;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam int ID_W    = 16;
    localparam int BURST_W = 16;
    localparam int TICK_W  = 24;
    localparam int STAT_W  = 2;

    // request function codes
    localparam logic FUNC_ARRIVE = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_RAN  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_IDLE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

    // one slot of the job table as it sits in memory
    typedef struct packed {
        logic [ID_W-1:0]    job;
        logic [TICK_W-1:0]  arrival;
        logic [BURST_W-1:0] remaining;
        logic [BURST_W-1:0] burst;
        logic               started;
        logic [TICK_W-1:0]  response;
    } slot_rec_t;

    // result payload
    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [ID_W-1:0]    ran_id;
        logic               finished;
        logic [TICK_W-1:0]  tick_now;
        logic [TICK_W-1:0]  completion_at;
        logic [TICK_W-1:0]  turnaround;
        logic [TICK_W-1:0]  wait_ticks;
        logic [TICK_W-1:0]  first_response;
    } rsp_t;

endpackage

`default_nettype wire

// ===== design/srtf_ifs.sv =====
// request and result channel interfaces of the srtf scheduler
`default_nettype none

interface srtf_req_if
    import srtf_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               func;
    logic [ID_W-1:0]    job_id;
    logic [BURST_W-1:0] burst_len;

    modport source (output valid, output func, output job_id, output burst_len, input ready);
    modport sink   (input valid, input func, input job_id, input burst_len, output ready);
endinterface

interface srtf_rsp_if
    import srtf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   ran_id;
    logic              finished;
    logic [TICK_W-1:0] tick_now;
    logic [TICK_W-1:0] completion_at;
    logic [TICK_W-1:0] turnaround;
    logic [TICK_W-1:0] wait_ticks;
    logic [TICK_W-1:0] first_response;

    modport source (output valid, output status, output ran_id, output finished,
                    output tick_now, output completion_at, output turnaround,
                    output wait_ticks, output first_response, input ready);
    modport sink   (input valid, input status, input ran_id, input finished,
                    input tick_now, input completion_at, input turnaround,
                    input wait_ticks, input first_response, output ready);
endinterface

`default_nettype wire

// ===== design/srtf_preemptive_scheduler.sv =====
// shortest-remaining-time-first scheduler with its job table in one memory
// arrive request: a scan of the valid bits, one slot a cycle, finds the lowest free slot and
// writes the job there with no result; when the table is full, a reject result is built
// tick request: one memory read per slot, then the chosen job is written back and a result built
// a result waits in the output register; one request is worked at a time
// reset clears the valid bits and the tick counter; the table memory keeps its contents
`default_nettype none

module srtf_preemptive_scheduler
    import srtf_pkg::*;
(
    input  wire            clk,
    input  wire            rst_n,
    srtf_req_if.sink       req,
    srtf_rsp_if.source     rsp
);

    // one-hot sequencer states
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,  // waiting for a request
        S_FREE = 5'b00010,  // arrival: looking for the lowest free slot
        S_SCAN = 5'b00100,  // tick: reading one slot per cycle
        S_LAST = 5'b01000,  // tick: last read lands in the compare stage
        S_EMIT = 5'b10000   // write back and load the output register
    } state_t;

    state_t             state_reg, state_next;
    logic [SLOT_W-1:0]  cnt_reg, cnt_next;
    logic               op_reg;
    logic [ID_W-1:0]    id_reg;
    logic [BURST_W-1:0] burst_reg;
    logic [TICK_W-1:0]  tick_reg;
    logic [SLOTS-1:0]   valid_reg;

    // job table memory, one synchronous read port and one write port
    slot_rec_t          mem [SLOTS];
    slot_rec_t          rd_data_reg;
    logic               rd_pend_reg;
    logic               rd_vbit_reg;
    logic [SLOT_W-1:0]  rd_idx_reg;

    // best candidate found so far in the scan
    logic               found_reg;
    slot_rec_t          best_reg;
    logic [SLOT_W-1:0]  best_idx_reg;
    logic [TICK_W-1:0]  best_age_reg;

    // output register
    logic               rsp_valid_reg;
    rsp_t               rsp_reg, rsp_next;

    logic               out_free;
    logic               req_fire;
    logic               rd_en;
    logic               wr_en;
    logic [SLOT_W-1:0]  wr_addr;
    slot_rec_t          wr_data;
    logic               set_valid;
    logic               clr_valid;
    logic               emit;
    logic [TICK_W-1:0]  age_rd;
    logic               better;
    logic [BURST_W-1:0] burst_fix;
    logic [TICK_W-1:0]  resp_val;
    logic               fin;
    logic [TICK_W-1:0]  done_tick;
    logic [TICK_W-1:0]  tat;
    logic               last_slot;
    logic               slot_free;

    assign req_fire  = req.valid && req.ready;
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign last_slot = (cnt_reg == SLOT_W'(SLOTS - 1));
    assign slot_free = !valid_reg[cnt_reg];

    // a zero burst counts as one tick of work
    assign burst_fix = (burst_reg == '0) ? BURST_W'(1) : burst_reg;

    // compare stage: shorter remaining wins, then the older job, then the lower slot
    assign age_rd = tick_reg - rd_data_reg.arrival;
    assign better = !found_reg
                 || (rd_data_reg.remaining < best_reg.remaining)
                 || ((rd_data_reg.remaining == best_reg.remaining) && (age_rd > best_age_reg));

    // figures of the chosen job
    assign resp_val  = best_reg.started ? best_reg.response : (tick_reg - best_reg.arrival);
    assign fin       = (best_reg.remaining <= BURST_W'(1));
    assign done_tick = tick_reg + TICK_W'(1);
    assign tat       = done_tick - best_reg.arrival;

    assign rd_en = (state_reg == S_SCAN);
    assign emit  = (state_reg == S_EMIT) && out_free;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (req_fire)
                begin
                    state_next = (req.func == FUNC_TICK) ? S_SCAN : S_FREE;
                end
            end
            S_FREE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
                else if (last_slot)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + SLOT_W'(1);
                end
            end
            S_SCAN:
            begin
                if (last_slot)
                begin
                    state_next = S_LAST;
                end
                else
                begin
                    cnt_next = cnt_reg + SLOT_W'(1);
                end
            end
            S_LAST:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // memory write: new job on arrival, updated job at the end of a tick
    always_comb
    begin
        wr_en     = 1'b0;
        wr_addr   = cnt_reg;
        wr_data   = best_reg;
        set_valid = 1'b0;
        clr_valid = 1'b0;
        if ((state_reg == S_FREE) && slot_free)
        begin
            wr_en             = 1'b1;
            set_valid         = 1'b1;
            wr_data.job       = id_reg;
            wr_data.arrival   = tick_reg;
            wr_data.remaining = burst_fix;
            wr_data.burst     = burst_fix;
            wr_data.started   = 1'b0;
            wr_data.response  = '0;
        end
        else if (emit && (op_reg == FUNC_TICK) && found_reg)
        begin
            wr_en             = 1'b1;
            wr_addr           = best_idx_reg;
            wr_data.started   = 1'b1;
            wr_data.response  = resp_val;
            wr_data.remaining = fin ? '0 : (best_reg.remaining - BURST_W'(1));
            clr_valid         = fin;
        end
    end

    // result build
    always_comb
    begin
        rsp_next          = '0;
        rsp_next.tick_now = tick_reg;
        if (op_reg == FUNC_ARRIVE)
        begin
            rsp_next.status = STAT_FULL;
            rsp_next.ran_id = id_reg;
        end
        else if (!found_reg)
        begin
            rsp_next.status = STAT_IDLE;
        end
        else
        begin
            rsp_next.status         = STAT_RAN;
            rsp_next.ran_id         = best_reg.job;
            rsp_next.first_response = resp_val;
            if (fin)
            begin
                rsp_next.finished      = 1'b1;
                rsp_next.completion_at = done_tick;
                rsp_next.turnaround    = tat;
                rsp_next.wait_ticks    = tat - TICK_W'(best_reg.burst);
            end
        end
    end

    // table memory, no reset
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[cnt_reg];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            tick_reg      <= '0;
            valid_reg     <= '0;
            rd_pend_reg   <= 1'b0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rd_pend_reg <= rd_en;

            if (set_valid)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (clr_valid)
            begin
                valid_reg[wr_addr] <= 1'b0;
            end

            // a new tick starts with no candidate
            if (req_fire)
            begin
                found_reg <= 1'b0;
            end
            else if (rd_pend_reg && rd_vbit_reg && better)
            begin
                found_reg <= 1'b1;
            end

            // every tick request advances time, whatever the outcome
            if (emit && (op_reg == FUNC_TICK))
            begin
                tick_reg <= done_tick;
            end

            if (emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            op_reg    <= req.func;
            id_reg    <= req.job_id;
            burst_reg <= req.burst_len;
        end
        if (rd_en)
        begin
            rd_idx_reg  <= cnt_reg;
            rd_vbit_reg <= valid_reg[cnt_reg];
        end
        if (rd_pend_reg && rd_vbit_reg && better)
        begin
            best_reg     <= rd_data_reg;
            best_idx_reg <= rd_idx_reg;
            best_age_reg <= age_rd;
        end
        if (emit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.status         = rsp_reg.status;
    assign rsp.ran_id         = rsp_reg.ran_id;
    assign rsp.finished       = rsp_reg.finished;
    assign rsp.tick_now       = rsp_reg.tick_now;
    assign rsp.completion_at  = rsp_reg.completion_at;
    assign rsp.turnaround     = rsp_reg.turnaround;
    assign rsp.wait_ticks     = rsp_reg.wait_ticks;
    assign rsp.first_response = rsp_reg.first_response;

endmodule

`default_nettype wire

// ===== design/srtf_checker.sv =====
// port-level assertions of the srtf scheduler and their bind
`default_nettype none

module srtf_checker
    import srtf_pkg::*;
(
    input wire              clk,
    input wire              rst_n,
    input wire              req_valid,
    input wire              req_ready,
    input wire              rsp_valid,
    input wire              rsp_ready,
    input wire [STAT_W-1:0] status,
    input wire [ID_W-1:0]   ran_id,
    input wire              finished,
    input wire [TICK_W-1:0] first_response,
    input wire [TICK_W-1:0] completion_at
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(ran_id))
        else $error("stalled result changed");

    // the block is busy right after taking a request
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> status != 2'd3)
        else $error("undefined status");

    // only a job that ran can finish
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && finished |-> status == STAT_RAN)
        else $error("finish without a run");

    // idle ticks carry no job figures
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == STAT_IDLE |->
            ran_id == '0 && !finished && first_response == '0 && completion_at == '0)
        else $error("idle tick with job data");

endmodule

bind srtf_preemptive_scheduler srtf_checker u_srtf_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .status         (rsp.status),
    .ran_id         (rsp.ran_id),
    .finished       (rsp.finished),
    .first_response (rsp.first_response),
    .completion_at  (rsp.completion_at)
);

`default_nettype wire
